### hdl/rsdf_pkg.sv
`timescale 1ns / 1ps
// Package for the frame deframer: byte codes, verdict codes and the result record.
// Used by the result queue and the top level.
package rsdf_pkg;

  localparam logic [7:0] ByteStx = 8'h02;
  localparam logic [7:0] ByteEtx = 8'h03;
  localparam logic [7:0] ByteEot = 8'h04;
  localparam logic [7:0] BytePol = 8'h05;
  localparam logic [7:0] ByteAck = 8'h06;
  localparam logic [7:0] ByteNak = 8'h15;
  localparam logic [7:0] NoAddress = 8'hFF;

  // Largest payload a select or respond frame may carry.
  localparam int unsigned MaxPayload = 256;
  // Byte position saturates here.
  localparam logic [9:0] PosMax = 10'd1023;
  // Default depth of the result queue (power of two, at least 4).
  localparam int unsigned ResDepthDefault = 4;

  typedef enum logic [2:0] {
    VERD_NONE    = 3'd0,
    VERD_ACK     = 3'd1,
    VERD_NACK    = 3'd2,
    VERD_EOT     = 3'd3,
    VERD_POLL    = 3'd4,
    VERD_SELECT  = 3'd5,
    VERD_RESPOND = 3'd6,
    VERD_ERROR   = 3'd7
  } verdict_e;

  typedef struct packed {
    logic       is_verdict;
    logic [7:0] payload_byte;
    verdict_e   verdict;
    logic [7:0] station_address;
    logic [7:0] operation_code;
    logic [8:0] payload_count;
    logic       run_last;
  } res_t;

  // What the deframer hands to the result queue in one cycle.
  typedef struct packed {
    logic [1:0] n;        // number of results written this cycle
    res_t       first;
    res_t       second;
  } push_t;

endpackage

### hdl/rsdf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and for deframer results.
// Depends on nothing.
interface rsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface rsdf_out_if;
  logic       valid;
  logic       ready;
  logic       is_verdict;
  logic [7:0] payload_byte;
  logic [2:0] verdict;
  logic [7:0] station_address;
  logic [7:0] operation_code;
  logic [8:0] payload_count;
  logic       run_last;

  modport source (output valid, output is_verdict, output payload_byte, output verdict,
                  output station_address, output operation_code, output payload_count,
                  output run_last, input ready);
  modport sink (input valid, input is_verdict, input payload_byte, input verdict,
                input station_address, input operation_code, input payload_count,
                input run_last, output ready);
endinterface

### hdl/rsdf_res_fifo.sv
`timescale 1ns / 1ps
// Result queue of the deframer: takes up to two results a cycle, gives one.
// Depends on rsdf_pkg.
module rsdf_res_fifo #(
  parameter int unsigned Depth = rsdf_pkg::ResDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsdf_pkg::push_t     push_i,
  output logic                space_o,
  output logic                valid_o,
  output rsdf_pkg::res_t      head_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rsdf_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  // Room for two results means any byte can be taken.
  assign space_o = (cnt_q <= CntW'(Depth - 2));
  assign wr_next = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.n);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count exceeds depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> cnt_q <= CntW'(Depth - 2))
    else $error("results written without room");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(wr_q - rd_q) == cnt_q[PtrW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

### hdl/rs485_frame_deframer.sv
`timescale 1ns / 1ps
// A result is written into the result queue when the byte that causes it is taken.
// Throughput: one byte per cycle while the result queue has room for two results; a last
// byte that also releases a payload byte gives two, which leave the queue (ResDepth entries) one at a time.
// Reset: rst_ni, asynchronous and active low, clears the frame state and empties the
// queue; the block is ready for bytes as soon as reset is released.
module rs485_frame_deframer #(
  parameter int unsigned ResDepth = rsdf_pkg::ResDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rsdf_in_if.sink    rx_i,
  rsdf_out_if.source res_o
);

  // Frame state. Every register goes back to its reset value after the last byte of a
  // frame, so each frame starts clean.
  logic [9:0] pos_q, pos_d;
  logic [7:0] lead_q, lead_d;
  logic [7:0] second_q, second_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] op_q, op_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] dly0_q, dly0_d;
  logic [7:0] dly1_q, dly1_d;
  logic       ovf_q, ovf_d;

  logic       accept;
  logic [7:0] b;
  logic       is_end;
  logic       is_sel, is_rsp;
  logic [9:0] pstart2, xstart, idx;
  logic       pay_win, fits, emit, ovf_c;
  logic [10:0] len;
  logic       bcc_ok, etx_ok;
  rsdf_pkg::verdict_e verd;
  logic [7:0] v_addr, v_op;
  logic [10:0] v_cnt;
  rsdf_pkg::res_t pay_res, verd_res;
  rsdf_pkg::push_t push;
  logic       space;
  rsdf_pkg::res_t head;

  assign accept = rx_i.valid && rx_i.ready;
  assign b      = rx_i.rx_byte;
  assign is_end = rx_i.frame_end;
  assign len    = {1'b0, pos_q} + 11'd1;

  // Classification. The leading and second bytes are taken from the incoming byte
  // at their own positions, so the byte just arriving already counts.
  always_comb begin
    lead_d   = (pos_q == 10'd0) ? b : lead_q;
    second_d = (pos_q == 10'd1) ? b : second_q;
    is_sel   = (pos_q != 10'd0) && (lead_d == rsdf_pkg::ByteEot)
               && (second_d == rsdf_pkg::ByteStx);
    is_rsp   = (lead_d == rsdf_pkg::ByteStx);
    // A select frame carries one more header byte than a respond frame.
    pstart2  = is_sel ? 10'd6 : 10'd5;
    xstart   = is_sel ? 10'd2 : 10'd1;

    addr_d = addr_q;
    op_d   = op_q;
    if (is_sel) begin
      if (pos_q == 10'd2) addr_d = b;
      if (pos_q == 10'd3) op_d = b;
    end else if (is_rsp) begin
      if (pos_q == 10'd1) addr_d = b;
      if (pos_q == 10'd2) op_d = b;
    end

    // A data byte leaves the two-byte delay once two later bytes show that it is
    // neither the ETX nor the BCC. Past the payload limit nothing more is released.
    pay_win = (is_sel || is_rsp) && (pos_q >= pstart2) && !ovf_q
              && (pos_q != rsdf_pkg::PosMax);
    idx     = pos_q - pstart2;
    fits    = ({3'b000, idx} < 13'(rsdf_pkg::MaxPayload));
    emit    = pay_win && fits;
    ovf_c   = ovf_q || (pos_q == rsdf_pkg::PosMax) || (pay_win && !fits);
  end

  // End-of-frame verdict.
  always_comb begin
    bcc_ok = (xor_q == b);
    etx_ok = (dly0_q == rsdf_pkg::ByteEtx);
    verd   = rsdf_pkg::VERD_ERROR;
    v_addr = rsdf_pkg::NoAddress;
    v_op   = 8'h00;
    v_cnt  = 11'd0;
    case (lead_d)
      rsdf_pkg::ByteAck: begin
        verd = (len == 11'd1) ? rsdf_pkg::VERD_ACK : rsdf_pkg::VERD_ERROR;
      end
      rsdf_pkg::ByteNak: begin
        verd = (len == 11'd1) ? rsdf_pkg::VERD_NACK : rsdf_pkg::VERD_ERROR;
      end
      rsdf_pkg::ByteEot: begin
        if (len == 11'd1) begin
          verd = rsdf_pkg::VERD_EOT;
        end else if (len == 11'd3) begin
          // Poll: EOT, address, POL.
          if (b == rsdf_pkg::BytePol) begin
            verd   = rsdf_pkg::VERD_POLL;
            v_addr = second_d;
          end
        end else if (len > 11'd3) begin
          if ((second_d == rsdf_pkg::ByteStx) && etx_ok) begin
            // Select frames too short to hold the header, ETX and BCC stay an error.
            if (len >= 11'd6) begin
              v_addr = addr_d;
              v_op   = op_d;
              v_cnt  = len - 11'd6;
              verd   = (!ovf_c && bcc_ok) ? rsdf_pkg::VERD_SELECT : rsdf_pkg::VERD_ERROR;
            end
          end else begin
            verd = rsdf_pkg::VERD_NONE;
          end
        end
      end
      rsdf_pkg::ByteStx: begin
        if (len <= 11'd3) begin
          verd = rsdf_pkg::VERD_NONE;
        end else if (etx_ok && (len >= 11'd5)) begin
          v_addr = addr_d;
          v_op   = op_d;
          v_cnt  = len - 11'd5;
          if (ovf_c) begin
            verd = rsdf_pkg::VERD_ERROR;
          end else begin
            // A checksum mismatch on a respond frame is reported as no frame at all.
            verd = bcc_ok ? rsdf_pkg::VERD_RESPOND : rsdf_pkg::VERD_NONE;
          end
        end
      end
      default: begin
        verd = rsdf_pkg::VERD_NONE;
      end
    endcase
  end

  // Results of this byte: the released payload byte first, then the verdict.
  always_comb begin
    pay_res.is_verdict      = 1'b0;
    pay_res.payload_byte    = dly1_q;
    pay_res.verdict         = rsdf_pkg::VERD_NONE;
    pay_res.station_address = rsdf_pkg::NoAddress;
    pay_res.operation_code  = 8'h00;
    pay_res.payload_count   = 9'd0;
    pay_res.run_last        = !is_end;

    verd_res.is_verdict      = 1'b1;
    verd_res.payload_byte    = 8'h00;
    verd_res.verdict         = verd;
    verd_res.station_address = v_addr;
    verd_res.operation_code  = v_op;
    verd_res.payload_count   = (v_cnt > 11'd511) ? 9'd511 : v_cnt[8:0];
    verd_res.run_last        = 1'b1;

    push.first  = emit ? pay_res : verd_res;
    push.second = verd_res;
    push.n      = accept ? (2'(emit) + 2'(is_end)) : 2'd0;
  end

  // Next frame state.
  always_comb begin
    if (is_end) begin
      pos_d  = 10'd0;
      xor_d  = 8'h00;
      dly0_d = 8'h00;
      dly1_d = 8'h00;
      ovf_d  = 1'b0;
    end else begin
      pos_d  = (pos_q < rsdf_pkg::PosMax) ? pos_q + 10'd1 : rsdf_pkg::PosMax;
      xor_d  = ((is_sel || is_rsp) && (pos_q >= xstart)) ? (xor_q ^ b) : xor_q;
      dly0_d = b;
      dly1_d = dly0_q;
      ovf_d  = ovf_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 10'd0;
      lead_q   <= 8'h00;
      second_q <= 8'h00;
      addr_q   <= rsdf_pkg::NoAddress;
      op_q     <= 8'h00;
      xor_q    <= 8'h00;
      dly0_q   <= 8'h00;
      dly1_q   <= 8'h00;
      ovf_q    <= 1'b0;
    end else if (accept) begin
      pos_q    <= pos_d;
      lead_q   <= is_end ? 8'h00 : lead_d;
      second_q <= is_end ? 8'h00 : second_d;
      addr_q   <= is_end ? rsdf_pkg::NoAddress : addr_d;
      op_q     <= is_end ? 8'h00 : op_d;
      xor_q    <= xor_d;
      dly0_q   <= dly0_d;
      dly1_q   <= dly1_d;
      ovf_q    <= ovf_d;
    end
  end

  // Results are queued so that a transfer can be taken while earlier results wait.
  rsdf_res_fifo #(
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (res_o.valid),
    .head_o  (head),
    .pop_i   (res_o.ready)
  );

  assign rx_i.ready            = space;
  assign res_o.is_verdict      = head.is_verdict;
  assign res_o.payload_byte    = head.payload_byte;
  assign res_o.verdict         = head.verdict;
  assign res_o.station_address = head.station_address;
  assign res_o.operation_code  = head.operation_code;
  assign res_o.payload_count   = head.payload_count;
  assign res_o.run_last        = head.run_last;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_end |=> pos_q == 10'd0)
    else $error("frame state not cleared after last byte");

  a_two_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> accept && is_end)
    else $error("two results from a byte that does not end the frame");

  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == 10'd0 |-> addr_q == rsdf_pkg::NoAddress && xor_q == 8'h00 && !ovf_q)
    else $error("frame start with stale state");
`endif

endmodule
